// ===== hdl/jses_pkg.sv =====
package jses_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } out_item_t;

    // Characters used in escapes
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_2       = 8'h32;
    localparam logic [7:0] CH_5       = 8'h35;
    localparam logic [7:0] CTRL_END   = 8'h20;
    localparam logic [7:0] ASCII_END  = 8'h80;

    // UTF-8 lead ranges and special leads
    localparam logic [7:0] LEAD_MIN   = 8'hC2;
    localparam logic [7:0] LEAD3_MIN  = 8'hE0;
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD_END   = 8'hF5;
    localparam logic [7:0] LEAD_E0    = 8'hE0;
    localparam logic [7:0] LEAD_ED    = 8'hED;
    localparam logic [7:0] LEAD_F0    = 8'hF0;
    localparam logic [7:0] LEAD_F4    = 8'hF4;
    localparam logic [7:0] E0_CONT_MIN = 8'hA0;
    localparam logic [7:0] ED_CONT_MAX = 8'h9F;
    localparam logic [7:0] F0_CONT_MIN = 8'h90;
    localparam logic [7:0] F4_CONT_MAX = 8'h8F;
    localparam logic [1:0] CONT_TAG    = 2'b10;

    // Register map
    localparam logic REG_ESCAPE_MODE = 1'b0;

    localparam int MAX_BURST = 15;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] n8;
        n8 = {4'h0, nib};
        return (nib < 4'd10) ? (8'h30 + n8) : (8'h57 + n8);
    endfunction

    function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                     input logic [7:0] b);
        logic ok;
        ok = (b[7:6] == CONT_TAG);
        if (pos == 2'd1) begin
            if (lead == LEAD_E0 && b < E0_CONT_MIN) ok = 1'b0;
            if (lead == LEAD_ED && b > ED_CONT_MAX) ok = 1'b0;
            if (lead == LEAD_F0 && b < F0_CONT_MIN) ok = 1'b0;
            if (lead == LEAD_F4 && b > F4_CONT_MAX) ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

// ===== hdl/json_string_escaper_utf8_sanitizer_top.sv =====
// JSON string escaper with UTF-8 checking. Each accepted request (one string byte) is
// registered, then decoded into a burst of 0 to 15 output bytes that is loaded into a
// result buffer and drained one byte per cycle on the m_ side while m_ready is high. A
// request that yields zero or one byte does not hold the next one, so plain text streams
// at one byte per clock while m_ready stays high; a request that yields more bytes holds
// the next request until the single output port has drained the burst buffer down to its
// last byte. An input register accepts a new request while a burst is still draining.
// Partial UTF-8 sequences (up to three bytes) are held internally and emitted when they
// complete or fail. escape_mode sits at APB address 0 (bit 0, reset 1); write it only while the block is idle.
module json_string_escaper_utf8_sanitizer_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  jses_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output jses_pkg::out_item_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import jses_pkg::*;

    logic             mode_reg;
    logic             in_full_reg;
    in_item_t         in_data_reg;
    logic [1:0]       held_count_reg, held_count_next;
    logic [2:0]       exp_len_reg, exp_len_next;
    logic [7:0]       held_bytes_reg [3];
    logic [7:0]       burst_reg [MAX_BURST];
    logic [7:0]       burst_next [MAX_BURST];
    logic [3:0]       burst_cnt_reg, burst_cnt_next;
    logic             burst_end_reg;

    logic             take;
    logic             load;
    logic             cfg_wr;

    logic [7:0]       c;
    logic             last;
    logic             held_wr_en;
    logic [1:0]       held_wr_idx;

    logic [7:0]       src [3];
    logic [1:0]       src_n;
    logic             src_pct;
    logic [7:0]       pre_byte [MAX_BURST];
    logic [3:0]       pre_len;

    logic [7:0]       esc_byte [8];
    logic [2:0]       esc_len;
    logic             esc_hold;
    logic [2:0]       lead_len;

    logic [1:0]       fr_sel;
    logic [7:0]       fr_byte [8];
    logic [2:0]       fr_len;

    localparam logic [1:0] FR_NONE = 2'd0;
    localparam logic [1:0] FR_RAW  = 2'd1;
    localparam logic [1:0] FR_ESC  = 2'd2;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_ESCAPE_MODE) ? {31'b0, mode_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b1;
        end else if (cfg_wr && paddr[2] == REG_ESCAPE_MODE) begin
            mode_reg <= pwdata[0];
        end
    end

    // Handshake
    assign m_valid = (burst_cnt_reg != 4'd0);
    assign take    = m_valid && m_ready;
    assign load    = in_full_reg && ((burst_cnt_reg == 4'd0) || (burst_cnt_reg == 4'd1 && m_ready));
    assign s_ready = !in_full_reg || load;

    always_comb begin
        m_data.out_byte   = burst_reg[0];
        m_data.run_last   = (burst_cnt_reg == 4'd1);
        m_data.string_end = (burst_cnt_reg == 4'd1) && burst_end_reg;
    end

    assign c    = in_data_reg.in_byte;
    assign last = in_data_reg.string_last;

    // Fresh byte escape
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            esc_byte[i] = 8'h00;
        end
        esc_len  = 3'd0;
        esc_hold = 1'b0;
        lead_len = (c < LEAD3_MIN) ? 3'd2 : (c < LEAD4_MIN) ? 3'd3 : 3'd4;
        case (c)
            CH_PERCENT: begin
                esc_byte[0] = CH_PERCENT; esc_byte[1] = CH_2; esc_byte[2] = CH_5;
                esc_len = 3'd3;
            end
            CH_QUOTE: begin
                esc_byte[0] = CH_BSLASH; esc_byte[1] = CH_QUOTE; esc_len = 3'd2;
            end
            CH_BSLASH: begin
                esc_byte[0] = CH_BSLASH; esc_byte[1] = CH_BSLASH; esc_len = 3'd2;
            end
            CH_LF: begin
                esc_byte[0] = CH_BSLASH; esc_byte[1] = CH_N; esc_len = 3'd2;
            end
            CH_CR: begin
                esc_byte[0] = CH_BSLASH; esc_byte[1] = CH_R; esc_len = 3'd2;
            end
            CH_TAB: begin
                esc_byte[0] = CH_BSLASH; esc_byte[1] = CH_T; esc_len = 3'd2;
            end
            default: begin
                if (c < CTRL_END) begin
                    esc_byte[0] = CH_BSLASH; esc_byte[1] = CH_U;
                    esc_byte[2] = CH_0;      esc_byte[3] = CH_0;
                    esc_byte[4] = hex_char(c[7:4]);
                    esc_byte[5] = hex_char(c[3:0]);
                    esc_len = 3'd6;
                end else if (c < ASCII_END) begin
                    esc_byte[0] = c;
                    esc_len = 3'd1;
                end else if (c >= LEAD_MIN && c < LEAD_END && !last) begin
                    esc_hold = 1'b1;
                end else begin
                    esc_byte[0] = CH_PERCENT;
                    esc_byte[1] = hex_char(c[7:4]);
                    esc_byte[2] = hex_char(c[3:0]);
                    esc_len = 3'd3;
                end
            end
        endcase
    end

    // Sequence tracking: pick the held-byte prefix and what follows it
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            src[i] = held_bytes_reg[i];
        end
        src_n           = held_count_reg;
        src_pct         = 1'b0;
        fr_sel          = FR_ESC;
        held_count_next = 2'd0;
        exp_len_next    = 3'd0;
        held_wr_en      = 1'b0;
        held_wr_idx     = 2'd0;

        if (!mode_reg) begin
            fr_sel = FR_RAW;
        end else if (held_count_reg != 2'd0) begin
            if (cont_ok(held_bytes_reg[0], held_count_reg, c)) begin
                if ({1'b0, held_count_reg} + 3'd1 >= exp_len_reg) begin
                    fr_sel = FR_RAW;
                end else begin
                    held_wr_en  = 1'b1;
                    held_wr_idx = held_count_reg;
                    fr_sel      = FR_NONE;
                    if (last) begin
                        // cut off by string end: flush held plus this byte as %xx
                        for (int i = 0; i < 3; i++) begin
                            if (2'(i) == held_count_reg) src[i] = c;
                        end
                        src_n   = held_count_reg + 2'd1;
                        src_pct = 1'b1;
                    end else begin
                        src_n           = 2'd0;
                        held_count_next = held_count_reg + 2'd1;
                        exp_len_next    = exp_len_reg;
                    end
                end
            end else begin
                src_pct = 1'b1;
            end
        end else begin
            src_n = 2'd0;
        end

        if (fr_sel == FR_ESC && esc_hold) begin
            held_wr_en      = 1'b1;
            held_wr_idx     = 2'd0;
            held_count_next = 2'd1;
            exp_len_next    = lead_len;
        end
    end

    // Prefix bytes
    always_comb begin
        for (int i = 0; i < MAX_BURST; i++) begin
            pre_byte[i] = 8'h00;
        end
        for (int i = 0; i < 3; i++) begin
            if (src_pct) begin
                pre_byte[3*i]   = CH_PERCENT;
                pre_byte[3*i+1] = hex_char(src[i][7:4]);
                pre_byte[3*i+2] = hex_char(src[i][3:0]);
            end else begin
                pre_byte[i] = src[i];
            end
        end
        pre_len = src_pct ? (4'({2'b0, src_n}) * 4'd3) : {2'b0, src_n};
    end

    // Tail bytes
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            fr_byte[i] = esc_byte[i];
        end
        fr_len = esc_len;
        case (fr_sel)
            FR_NONE: begin
                fr_len = 3'd0;
            end
            FR_RAW: begin
                fr_byte[0] = c;
                fr_len     = 3'd1;
            end
            default: begin
                fr_len = esc_len;
            end
        endcase
    end

    // Assemble the burst: shift down on take, replace on load
    always_comb begin
        logic [3:0] off;
        off = 4'd0;
        burst_cnt_next = burst_cnt_reg;
        for (int k = 0; k < MAX_BURST; k++) begin
            burst_next[k] = burst_reg[k];
        end
        if (load) begin
            burst_cnt_next = pre_len + {1'b0, fr_len};
            for (int k = 0; k < MAX_BURST; k++) begin
                off = 4'(k) - pre_len;
                if (4'(k) < pre_len) begin
                    burst_next[k] = pre_byte[k];
                end else begin
                    burst_next[k] = fr_byte[off[2:0]];
                end
            end
        end else if (take) begin
            burst_cnt_next = burst_cnt_reg - 4'd1;
            for (int k = 0; k < MAX_BURST - 1; k++) begin
                burst_next[k] = burst_reg[k+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_full_reg    <= 1'b0;
            held_count_reg <= 2'd0;
            exp_len_reg    <= 3'd0;
            burst_cnt_reg  <= 4'd0;
        end else begin
            if (s_valid && s_ready) begin
                in_full_reg <= 1'b1;
            end else if (load) begin
                in_full_reg <= 1'b0;
            end
            if (load) begin
                held_count_reg <= held_count_next;
                exp_len_reg    <= exp_len_next;
            end
            burst_cnt_reg <= burst_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (load) begin
            burst_end_reg <= last;
        end
        if (load && held_wr_en) begin
            held_bytes_reg[held_wr_idx] <= c;
        end
        for (int k = 0; k < MAX_BURST; k++) begin
            burst_reg[k] <= burst_next[k];
        end
    end

    // Checks
    a_len_above_count: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg != 2'd0 |-> exp_len_reg > {1'b0, held_count_reg})
        else $error("expected length not above held count");

    a_len_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg == 2'd0 |-> exp_len_reg == 3'd0)
        else $error("expected length left set with nothing held");

    a_burst_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        burst_cnt_reg != 4'd0 && !m_ready |=> burst_cnt_reg == $past(burst_cnt_reg))
        else $error("burst count moved while output stalled");

    a_plain_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        load && !mode_reg |=> held_count_reg == 2'd0)
        else $error("plain mode left bytes held");

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        load && burst_cnt_reg != 4'd0 |-> m_ready)
        else $error("burst overwritten before drained");

endmodule
